// ----- rtl/qtps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtps_pkg
// Shared types and constants of the queued two-wire prompt sender.
// ----------------------------------------------------------------------------
package qtps_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int WordW      = 16;
  localparam int TickW      = 6;
  localparam int BitIdxW    = 5;
  localparam logic [BitIdxW-1:0] FrameBits = BitIdxW'(WordW);

  localparam int InDataW  = 24;
  localparam int OutDataW = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMMAND_WORD = 2'd0,
    CFG_START_TICKS  = 2'd1,
    CFG_STOP_TICKS   = 2'd2,
    CFG_GAP_TICKS    = 2'd3
  } cfg_idx_t;

  // item kinds
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [WordW-1:0] prompt;
    logic             device_busy;
  } item_t;

  // engine to prompt queue
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [WordW-1:0] word;
  } pq_ctrl_t;

  // prompt queue to engine
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [WordW-1:0]  head;
    logic [CountW-1:0] count;
  } pq_stat_t;

endpackage
`default_nettype wire

// ----- rtl/qtps_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtps_front
// Input side: takes stream transactions, classifies them as tick or push and
// holds them in a two-entry queue for the line engine.
// ----------------------------------------------------------------------------
module qtps_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [qtps_pkg::InDataW-1:0] s_tdata,
  input  wire logic                         s_tuser,
  output logic                              item_valid,
  output qtps_pkg::item_t                   item,
  input  wire logic                         item_pop
);
  import qtps_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       incoming;

  always_comb begin
    incoming.op          = s_tuser ? OP_PUSH : OP_TICK;
    incoming.prompt      = s_tdata[WordW-1:0];
    incoming.device_busy = s_tdata[WordW];
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/qtps_prompt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtps_prompt_queue
// Circular store of prompt words with read and write pointers and a count.
// ----------------------------------------------------------------------------
module qtps_prompt_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qtps_pkg::pq_ctrl_t ctrl,
  output qtps_pkg::pq_stat_t      stat
);
  import qtps_pkg::*;

  logic [WordW-1:0]  store [QueueDepth];
  logic [PtrW-1:0]   read_pointer;
  logic [PtrW-1:0]   read_pointer_next;
  logic [PtrW-1:0]   write_pointer;
  logic [CountW-1:0] entry_count;
  logic [WordW-1:0]  head;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign read_pointer_next = ctrl.pop ? wrap_inc(read_pointer) : read_pointer;

  always_comb begin
    stat.full  = (entry_count == CountW'(QueueDepth));
    stat.empty = (entry_count == '0);
    stat.head  = head;
    stat.count = entry_count;
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      store[write_pointer] <= ctrl.word;
    end
  end

  // registered head, a push into the slot about to be read goes straight through
  always_ff @(posedge clk) begin
    if (ctrl.push && write_pointer == read_pointer_next) begin
      head <= ctrl.word;
    end else begin
      head <= store[read_pointer_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      entry_count   <= '0;
    end else begin
      if (ctrl.push) begin
        write_pointer <= wrap_inc(write_pointer);
      end
      read_pointer <= read_pointer_next;
      entry_count  <= entry_count + CountW'(ctrl.push) - CountW'(ctrl.pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/qtps_line_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtps_line_engine
// Back end: holds the configuration, runs the clock/data line sequencer one
// item per cycle while the output register is empty or being taken, and registers each result for the output stream.
// ----------------------------------------------------------------------------
module qtps_line_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [qtps_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [qtps_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          item_valid,
  input  wire qtps_pkg::item_t               item,
  output logic                               item_pop,
  output qtps_pkg::pq_ctrl_t                 pq_ctrl,
  input  wire qtps_pkg::pq_stat_t            pq_stat,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [qtps_pkg::OutDataW-1:0]      m_tdata
);
  import qtps_pkg::*;

  logic [WordW-1:0]   command_word;
  logic [TickW-1:0]   start_bit_ticks;
  logic [TickW-1:0]   stop_hold_ticks;
  logic [TickW-1:0]   frame_gap_ticks;

  logic [WordW-1:0]   shift_word,  shift_word_next;
  logic [BitIdxW-1:0] bit_index,   bit_index_next;
  logic               sending,     sending_next;
  logic [TickW-1:0]   phase_ticks, phase_ticks_next;
  logic               clock_level, clock_level_next;
  logic               data_level,  data_level_next;

  logic               fire;
  logic               dropped;
  logic               done;
  logic               tick;
  logic [CountW-1:0]  count_next;

  assign fire     = item_valid && (!m_tvalid || m_tready);
  assign item_pop = fire;
  assign tick     = fire && (item.op == OP_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      command_word    <= '0;
      start_bit_ticks <= TickW'(4);
      stop_hold_ticks <= TickW'(48);
      frame_gap_ticks <= TickW'(60);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COMMAND_WORD: command_word    <= cfg_data[WordW-1:0];
        CFG_START_TICKS:  start_bit_ticks <= cfg_data[TickW-1:0];
        CFG_STOP_TICKS:   stop_hold_ticks <= cfg_data[TickW-1:0];
        CFG_GAP_TICKS:    frame_gap_ticks <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shift_word_next  = shift_word;
    bit_index_next   = bit_index;
    sending_next     = sending;
    phase_ticks_next = phase_ticks;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    done             = 1'b0;
    dropped          = 1'b0;
    pq_ctrl.push     = 1'b0;
    pq_ctrl.pop      = 1'b0;
    pq_ctrl.word     = item.prompt;

    if (fire && item.op == OP_PUSH) begin
      if (pq_stat.full) begin
        dropped = 1'b1;
      end else begin
        pq_ctrl.push = 1'b1;
      end
    end

    if (tick) begin
      // frame start: command word wins, queue needs an idle module
      if (bit_index == '0 && !sending) begin
        if (command_word != '0) begin
          shift_word_next = command_word;
          sending_next    = 1'b1;
        end else if (item.device_busy || pq_stat.empty) begin
          done = 1'b1;
        end else begin
          shift_word_next = pq_stat.head;
          pq_ctrl.pop     = 1'b1;
          sending_next    = 1'b1;
        end
      end

      // lead delay and start bit
      if (!done && sending_next && phase_ticks != '0 && bit_index == '0) begin
        if (phase_ticks < start_bit_ticks) begin
          clock_level_next = 1'b0;
        end
        phase_ticks_next = phase_ticks - TickW'(1);
        done = 1'b1;
      end

      // stop bit hold
      if (!done && sending_next && phase_ticks != '0 && bit_index == FrameBits) begin
        data_level_next  = 1'b0;
        clock_level_next = 1'b1;
        phase_ticks_next = phase_ticks - TickW'(1);
        done = 1'b1;
      end

      if (!done && bit_index == FrameBits && phase_ticks == '0) begin
        bit_index_next   = '0;
        sending_next     = 1'b0;
        phase_ticks_next = frame_gap_ticks;
        done = 1'b1;
      end

      // data bits: set data while clock low, then raise clock
      if (!done && bit_index < FrameBits && sending_next) begin
        if (!clock_level) begin
          phase_ticks_next = stop_hold_ticks;
          if (shift_word_next[WordW-1]) begin
            data_level_next = 1'b1;
          end
          shift_word_next  = {shift_word_next[WordW-2:0], 1'b0};
          bit_index_next   = bit_index + BitIdxW'(1);
          clock_level_next = 1'b1;
        end else begin
          clock_level_next = 1'b0;
          data_level_next  = 1'b0;
        end
      end
    end
  end

  assign count_next = pq_stat.count + CountW'(pq_ctrl.push) - CountW'(pq_ctrl.pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word  <= '0;
      bit_index   <= '0;
      sending     <= 1'b0;
      phase_ticks <= TickW'(4);
      clock_level <= 1'b0;
      data_level  <= 1'b0;
    end else if (tick) begin
      shift_word  <= shift_word_next;
      bit_index   <= bit_index_next;
      sending     <= sending_next;
      phase_ticks <= phase_ticks_next;
      clock_level <= clock_level_next;
      data_level  <= data_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {7'd0, dropped, count_next, sending_next,
                  data_level_next, clock_level_next};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/queued_two_wire_prompt_sender.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// queued_two_wire_prompt_sender
// Prompt queue and two-wire frame sender for an audio module.
// ----------------------------------------------------------------------------
// Input stream s_*: each transaction is either a half millisecond tick
// (s_tuser = 0) carrying the sampled module busy line, or a push of a prompt
// word (s_tuser = 1). Output stream m_*: one result transaction per input
// transaction, in order, giving clock and data line levels, frame active,
// queued prompt count and a dropped flag for a push into a full queue.
// Each input is held in the front item queue and then in the output
// register before its result appears on m_*. Throughput is one
// transaction per cycle: a two-entry item queue at the front decouples input
// from the line engine, which retires one item per cycle into the output
// register whenever that register is empty or being taken.
// When m_tready is low the output register holds, the engine stops and the
// item queue fills; s_tready drops once both entries are held.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are expected while no transactions are in flight.
// Reset clears the queues, the line sequencer and the configuration to its
// defaults (command 0, start 4, stop hold 48, gap 60 ticks); no clearing pass.
// ----------------------------------------------------------------------------
module queued_two_wire_prompt_sender (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [15:0] prompt, [16] device_busy, [23:17] zero
  input  wire logic [qtps_pkg::InDataW-1:0]  s_tdata,
  // [0] operation
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] clock_line, [1] data_line, [2] frame_active, [7:3] queue_count,
  // [8] push_dropped, [15:9] zero
  output logic [qtps_pkg::OutDataW-1:0]      m_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [qtps_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [qtps_pkg::CfgDataW-1:0] cfg_data
);
  import qtps_pkg::*;

  logic     item_valid;
  item_t    item;
  logic     item_pop;
  pq_ctrl_t pq_ctrl;
  pq_stat_t pq_stat;

  qtps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  qtps_prompt_queue u_prompt_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (pq_ctrl),
    .stat (pq_stat)
  );

  qtps_line_engine u_line_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .pq_ctrl    (pq_ctrl),
    .pq_stat    (pq_stat),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
`default_nettype wire

// ----- rtl/qtps_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtps_checker
// Port-level checks of the prompt sender, bound to the top level.
// ----------------------------------------------------------------------------
module qtps_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [qtps_pkg::OutDataW-1:0] m_tdata
);
  import qtps_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:3] <= 5'(QueueDepth))
    else $error("queue count above depth");

  // a dropped push only ever reports a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:3] == 5'(QueueDepth))
    else $error("push dropped with room in queue");

  // input side never blocks while nothing is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(s_tvalid) && !m_tvalid && !$past(m_tvalid) |-> s_tready)
    else $error("input stalled while block idle");

endmodule

bind queued_two_wire_prompt_sender qtps_checker u_qtps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/queued_two_wire_prompt_sender_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queued_two_wire_prompt_sender_tb
// Self-checking bench for the prompt queue and two-wire frame sender.
// ----------------------------------------------------------------------------
// Ticks and prompt pushes go in on the input stream with random gaps, and the
// output stream is stalled at random. A line model in the bench tracks the
// queue, the frame sequencer and the line levels, and every result is checked
// field by field against it. The run goes through several timing settings
// (defaults, shortest, longest, zero, random) and command word overrides.
// ----------------------------------------------------------------------------
module queued_two_wire_prompt_sender_tb;
  import qtps_pkg::*;

  typedef struct packed {
    logic              dropped;
    logic [CountW-1:0] count;
    logic              active;
    logic              data_ln;
    logic              clock_ln;
  } line_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  queued_two_wire_prompt_sender uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---- line model ----
  logic [WordW-1:0]   cmd_reg;
  logic [TickW-1:0]   start_reg;
  logic [TickW-1:0]   stop_reg;
  logic [TickW-1:0]   gap_reg;
  logic [WordW-1:0]   q_words [QueueDepth];
  logic [PtrW-1:0]    q_rd;
  logic [PtrW-1:0]    q_wr;
  logic [CountW-1:0]  q_count;
  logic [WordW-1:0]   sh_word;
  logic [BitIdxW-1:0] bit_pos;
  logic               in_frame;
  logic [TickW-1:0]   phase_cnt;
  logic               clk_lvl;
  logic               dat_lvl;

  line_result_t line_expect_q[$];
  int           errors;
  int           results_seen;
  int           items_sent;
  bit           send_calm;
  bit           recv_calm;
  int           recv_wait;

  function automatic void advance_line(logic busy);
    if (bit_pos == 0 && !in_frame) begin
      if (cmd_reg != 0) begin
        sh_word = cmd_reg;
      end else begin
        if (busy || q_count == 0) return;
        sh_word = q_words[q_rd];
        q_rd    = q_rd + 1'b1;
        q_count = q_count - 1'b1;
      end
      in_frame = 1'b1;
    end
    if (in_frame && phase_cnt != 0) begin
      // lead delay / start bit
      if (bit_pos == 0) begin
        if (phase_cnt < start_reg) clk_lvl = 1'b0;
        phase_cnt = phase_cnt - 1'b1;
        return;
      end
      // stop bit hold
      if (bit_pos == FrameBits) begin
        dat_lvl   = 1'b0;
        clk_lvl   = 1'b1;
        phase_cnt = phase_cnt - 1'b1;
        return;
      end
    end
    if (bit_pos == FrameBits && phase_cnt == 0) begin
      bit_pos   = '0;
      in_frame  = 1'b0;
      phase_cnt = gap_reg;
      return;
    end
    if (bit_pos < FrameBits && in_frame) begin
      if (!clk_lvl) begin
        phase_cnt = stop_reg;
        if (sh_word[WordW-1]) dat_lvl = 1'b1;
        sh_word = sh_word << 1;
        bit_pos = bit_pos + 1'b1;
        clk_lvl = 1'b1;
      end else begin
        clk_lvl = 1'b0;
        dat_lvl = 1'b0;
      end
    end
  endfunction

  function automatic line_result_t predict_line_step(op_t op, logic [WordW-1:0] word,
                                                     logic busy);
    line_result_t r;
    r.dropped = 1'b0;
    if (op == OP_PUSH) begin
      if (q_count >= QueueDepth) begin
        r.dropped = 1'b1;
      end else begin
        q_words[q_wr] = word;
        q_wr    = q_wr + 1'b1;
        q_count = q_count + 1'b1;
      end
    end else begin
      advance_line(busy);
    end
    r.clock_ln = clk_lvl;
    r.data_ln  = dat_lvl;
    r.active   = in_frame;
    r.count    = q_count;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s at result %0d: got %0d want %0d", what, results_seen, got, want);
  endtask

  // ---- result checker and output stall ----
  always @(posedge clk) begin
    line_result_t want;
    line_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = line_result_t'(m_tdata[8:0]);
      if (line_expect_q.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        want = line_expect_q.pop_front();
        if (got.clock_ln !== want.clock_ln) report("clock_line", got.clock_ln, want.clock_ln);
        if (got.data_ln !== want.data_ln) report("data_line", got.data_ln, want.data_ln);
        if (got.active !== want.active) report("frame_active", got.active, want.active);
        if (got.count !== want.count) report("queue_count", got.count, want.count);
        if (got.dropped !== want.dropped) report("push_dropped", got.dropped, want.dropped);
      end
      results_seen++;
      if (results_seen % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
    end
  end

  always @(negedge clk) begin
    if (recv_wait > 0) begin
      m_tready  <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---- stimulus helpers ----
  task automatic send_item(op_t op, logic [WordW-1:0] word, logic busy);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, busy, word};
    do @(posedge clk); while (!s_tready);
    line_expect_q.push_back(predict_line_step(op, word, busy));
    items_sent++;
    if (items_sent % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk) s_tvalid <= 1'b0;
    while (line_expect_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (line_expect_q.size() != 0) report("leftover expectations", line_expect_q.size(), 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timing(logic [WordW-1:0] cmd, logic [TickW-1:0] start_t,
                              logic [TickW-1:0] stop_t, logic [TickW-1:0] gap_t);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COMMAND_WORD;
    cfg_data  <= cmd;
    @(negedge clk);
    cfg_index <= CFG_START_TICKS;
    cfg_data  <= CfgDataW'(start_t);
    @(negedge clk);
    cfg_index <= CFG_STOP_TICKS;
    cfg_data  <= CfgDataW'(stop_t);
    @(negedge clk);
    cfg_index <= CFG_GAP_TICKS;
    cfg_data  <= CfgDataW'(gap_t);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cmd_reg   = cmd;
    start_reg = start_t;
    stop_reg  = stop_t;
    gap_reg   = gap_t;
  endtask

  task automatic run_random_items(int n, int push_pct, int busy_pct);
    op_t op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TICK;
      send_item(op, WordW'($urandom), $urandom_range(0, 99) < busy_pct);
    end
  endtask

  // ---- tests ----
  task automatic test_queue_fill_and_drop();
    send_item(OP_TICK, 16'h0000, 1'b0);          // empty queue, idle
    send_item(OP_PUSH, 16'hFFFF, 1'b0);
    send_item(OP_PUSH, 16'h0000, 1'b1);
    send_item(OP_TICK, 16'hFFFF, 1'b1);          // module busy holds off the frame
    send_item(OP_PUSH, 16'h8000, 1'b0);
    send_item(OP_PUSH, 16'h0001, 1'b1);
    send_item(OP_PUSH, 16'hAAAA, 1'b0);
    send_item(OP_PUSH, 16'h5555, 1'b0);
    for (int i = 0; i < 10; i++) send_item(OP_PUSH, WordW'($urandom), i[0]);
    // queue full now
    send_item(OP_PUSH, 16'h1234, 1'b0);
    send_item(OP_PUSH, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_item(OP_TICK, WordW'($urandom), 1'b0);
    send_item(OP_TICK, 16'h0000, 1'b1);          // busy mid-frame is ignored
  endtask

  task automatic test_default_timing();
    run_random_items(100, 25, 40);
  endtask

  task automatic test_short_timing();
    write_timing(16'h0000, 6'd1, 6'd1, 6'd1);
    run_random_items(110, 20, 40);
  endtask

  task automatic test_command_override();
    write_timing(16'hFFFF, 6'd2, 6'd3, 6'd2);
    run_random_items(90, 20, 80);
  endtask

  task automatic test_long_timing();
    write_timing(16'h0001, 6'd63, 6'd63, 6'd63);
    run_random_items(110, 15, 50);
  endtask

  task automatic test_zero_ticks();
    write_timing(16'h0000, 6'd0, 6'd0, 6'd0);
    run_random_items(100, 30, 30);
  endtask

  task automatic test_random_timing();
    for (int k = 0; k < 3; k++) begin
      write_timing(($urandom_range(0, 1) == 0) ? 16'h0000 : WordW'($urandom),
                   TickW'($urandom_range(1, 8)), TickW'($urandom_range(1, 8)),
                   TickW'($urandom_range(1, 8)));
      run_random_items(40, 25, 35);
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_TICK;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_COMMAND_WORD;
    cfg_data     = '0;
    errors       = 0;
    results_seen = 0;
    items_sent   = 0;
    send_calm    = 1'b0;
    recv_calm    = 1'b0;
    recv_wait    = 0;
    cmd_reg      = '0;
    start_reg    = 6'd4;
    stop_reg     = 6'd48;
    gap_reg      = 6'd60;
    for (int i = 0; i < QueueDepth; i++) q_words[i] = '0;
    q_rd      = '0;
    q_wr      = '0;
    q_count   = '0;
    sh_word   = '0;
    bit_pos   = '0;
    in_frame  = 1'b0;
    phase_cnt = 6'd4;
    clk_lvl   = 1'b0;
    dat_lvl   = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_queue_fill_and_drop();
    test_default_timing();
    test_short_timing();
    test_command_override();
    test_long_timing();
    test_zero_ticks();
    test_random_timing();
    wait_drained();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
